### rtl/core/prq_pkg.sv
// Shared constants and types for the priority ready queue.
`default_nettype none
package prq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int ID_W = 8;
  localparam int PRI_W = 8;
  localparam int OCC_W = 6;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  typedef struct packed {
    logic [PRI_W-1:0] pri;
    logic [ID_W-1:0]  id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

### rtl/core/prq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module prq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### rtl/core/priority_ready_queue_core.sv
// Top level of the priority ready queue: sequencer, scan compare and compaction.
//
// Ready queue for a thread scheduler holding up to QUEUE_DEPTH entries in
// arrival order in one RAM. An enqueue transaction, and a dequeue on an empty
// queue, passes from idle through the execute state and the done state.
// A dequeue transaction scans every held entry through the RAM read port,
// one entry per cycle, with a single priority comparator that keeps the
// earliest of equal priorities. It then moves the entries behind the winner
// up by one place, one entry per cycle, over the same read port and the write
// port. A result waits in the done state while an earlier result still
// holds the output register. The input is ready only while the sequencer is
// idle, including while a finished result still waits at the output
// register. The entry RAM needs no clearing after reset.
`default_nettype none
module priority_ready_queue_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // thread_id[7:0], priority_req[15:8]
  input  wire logic        s_tuser,   // operation[0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [23:0] m_tdata,   // selected_id[7:0], selected_priority[15:8],
                                      // occupancy[21:16], zero[23:22]
  output logic      [1:0]  m_tuser    // status[1:0]
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_PICK,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t state;

  logic                              op;
  prq_pkg::entry_t                   item;
  logic [prq_pkg::CNT_W-1:0]         count;
  logic [prq_pkg::IDX_W-1:0]         data_idx;
  logic [prq_pkg::IDX_W-1:0]         best_idx;
  prq_pkg::entry_t                   best;
  logic [prq_pkg::ID_W-1:0]          res_id;
  logic [prq_pkg::PRI_W-1:0]         res_pri;
  logic [prq_pkg::STATUS_W-1:0]      res_status;

  logic                              ram_wr_en;
  logic [prq_pkg::IDX_W-1:0]         ram_wr_addr;
  prq_pkg::entry_t                   ram_wr_data;
  logic                              ram_rd_en;
  logic [prq_pkg::IDX_W-1:0]         ram_rd_addr;
  prq_pkg::entry_t                   ram_rd_data;

  logic [prq_pkg::CNT_W-1:0]         last_cnt;
  logic                              full;
  logic                              data_is_last;
  logic                              best_is_last;
  logic                              next_is_last;
  logic                              better;
  logic                              out_free;

  assign last_cnt = count - prq_pkg::CNT_W'(1);
  assign full = (count == prq_pkg::CNT_W'(prq_pkg::QUEUE_DEPTH));
  assign data_is_last = (prq_pkg::CNT_W'(data_idx) == last_cnt);
  assign best_is_last = (prq_pkg::CNT_W'(best_idx) == last_cnt);
  assign next_is_last = (prq_pkg::CNT_W'(data_idx) + prq_pkg::CNT_W'(1) == last_cnt);
  assign better = (data_idx == '0) || (ram_rd_data.pri > best.pri);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);

  always_comb begin
    ram_wr_en = 1'b0;
    ram_wr_addr = data_idx;
    ram_wr_data = ram_rd_data;
    ram_rd_en = 1'b0;
    ram_rd_addr = data_idx + prq_pkg::IDX_W'(1);
    unique case (state)
      S_EXEC: begin
        if (op == prq_pkg::OP_ENQUEUE) begin
          ram_wr_en = !full;
          ram_wr_addr = count[prq_pkg::IDX_W-1:0];
          ram_wr_data = item;
        end else begin
          ram_rd_en = 1'b1;
          ram_rd_addr = '0;
        end
      end
      S_SCAN: begin
        ram_rd_en = 1'b1;
      end
      S_PICK: begin
        ram_rd_en = 1'b1;
        ram_rd_addr = best_idx + prq_pkg::IDX_W'(1);
      end
      S_SHIFT: begin
        ram_wr_en = 1'b1;
        ram_rd_en = 1'b1;
        ram_rd_addr = data_idx + prq_pkg::IDX_W'(2);
      end
      default: begin
      end
    endcase
  end

  prq_ram #(
    .WIDTH (prq_pkg::ENTRY_W),
    .DEPTH (prq_pkg::QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op <= s_tuser;
            item.id <= s_tdata[7:0];
            item.pri <= s_tdata[15:8];
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_id <= '0;
          res_pri <= '0;
          res_status <= prq_pkg::ST_OK;
          if (op == prq_pkg::OP_ENQUEUE) begin
            if (full) begin
              res_status <= prq_pkg::ST_FULL;
            end else begin
              count <= count + prq_pkg::CNT_W'(1);
            end
            state <= S_DONE;
          end else if (count == '0) begin
            res_status <= prq_pkg::ST_EMPTY;
            state <= S_DONE;
          end else begin
            data_idx <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (better) begin
            best <= ram_rd_data;
            best_idx <= data_idx;
          end
          if (data_is_last) begin
            state <= S_PICK;
          end else begin
            data_idx <= data_idx + prq_pkg::IDX_W'(1);
          end
        end
        S_PICK: begin
          res_id <= best.id;
          res_pri <= best.pri;
          data_idx <= best_idx;
          if (best_is_last) begin
            count <= last_cnt;
            state <= S_DONE;
          end else begin
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (next_is_last) begin
            count <= last_cnt;
            state <= S_DONE;
          end else begin
            data_idx <= data_idx + prq_pkg::IDX_W'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata <= {2'b00, prq_pkg::OCC_W'(count), res_pri, res_id};
            m_tuser <= res_status;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
